/* sv/fir_dc_pkg.sv */
// fir_dc_pkg: shared types and constants of the delay-compensated fir filter
// used by fir_dc_cell, fir_dc_mac and fir_filter_delay_compensated_core
// no dependencies
`default_nettype none

package fir_dc_pkg;

  // default sizes of the tap chain and the sample path
  localparam int MAX_TAPS_DEF     = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // fixed field widths
  localparam int COEF_WIDTH  = 18;
  localparam int COEF_FRAC   = 17;
  localparam int COEF_IDX_W  = 5;
  localparam int TAPS_W      = 6;
  localparam int FRAME_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // group delay is half the tap count
  localparam int HALF_DIVISOR = 2;

  // input operation codes
  typedef enum logic {
    OP_COEF_WR = 1'b0,
    OP_SAMPLE  = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT = 2'd0,
    CFG_FRAME_LEN = 2'd1,
    CFG_TIME_REV  = 2'd2
  } cfg_idx_e;

  // control broadcast along the tap chain
  typedef struct packed {
    logic                         shift_in;  // newest sample enters cell 0
    logic                         smp_rot;   // sample ring moves toward cell 0
    logic                         coef_fwd;  // coefficient ring moves toward cell 0
    logic                         coef_bwd;  // coefficient ring moves away from cell 0
    logic                         wr_en;     // coefficient slot write
    logic [COEF_IDX_W-1:0]        wr_idx;
    logic signed [COEF_WIDTH-1:0] wr_val;
  } ring_ctrl_t;

  // control of the multiply-accumulate unit
  typedef struct packed {
    logic clr;    // start a new sum
    logic use_en; // product of this cycle belongs to the sum
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* sv/fir_dc_cell.sv */
// fir_dc_cell: one tap cell holding one window sample and one coefficient
// depends on fir_dc_pkg
`default_nettype none

module fir_dc_cell
  import fir_dc_pkg::*;
#(
  parameter int IDX = 0,
  parameter int SW  = SAMPLE_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ring_ctrl_t                   ctrl_i,
  input  wire logic signed [SW-1:0]         smp_prev_i,
  input  wire logic signed [SW-1:0]         smp_next_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_prev_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_next_i,
  output logic signed [SW-1:0]              smp_o,
  output logic signed [COEF_WIDTH-1:0]      coef_o
);

  // only the first slots are reachable through the index field
  localparam bit Writable = (IDX < (1 << COEF_IDX_W));

  logic signed [SW-1:0]         smp_d, smp_q;
  logic signed [COEF_WIDTH-1:0] coef_d, coef_q;
  logic                         hit;

  assign hit = Writable && (ctrl_i.wr_idx == COEF_IDX_W'(IDX));

  // sample slot: shift on a new sample, rotate during the sum
  always_comb begin
    smp_d = smp_q;
    if (ctrl_i.shift_in) begin
      smp_d = smp_prev_i;
    end else if (ctrl_i.smp_rot) begin
      smp_d = smp_next_i;
    end
  end

  // coefficient slot: direct write or rotation in either direction
  always_comb begin
    coef_d = coef_q;
    if (ctrl_i.wr_en && hit) begin
      coef_d = ctrl_i.wr_val;
    end else if (ctrl_i.coef_fwd) begin
      coef_d = coef_next_i;
    end else if (ctrl_i.coef_bwd) begin
      coef_d = coef_prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q  <= '0;
      coef_q <= '0;
    end else begin
      smp_q  <= smp_d;
      coef_q <= coef_d;
    end
  end

  assign smp_o  = smp_q;
  assign coef_o = coef_q;

endmodule

`default_nettype wire

/* sv/fir_dc_mac.sv */
// fir_dc_mac: registered multiplier, accumulator and round/saturate to the sample format
// depends on fir_dc_pkg
`default_nettype none

module fir_dc_mac
  import fir_dc_pkg::*;
#(
  parameter int SW       = SAMPLE_WIDTH_DEF,
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mac_ctrl_t                    ctrl_i,
  input  wire logic signed [SW-1:0]         smp_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_i,
  output logic signed [SW-1:0]              filtered_o
);

  localparam int PW = SW + COEF_WIDTH;
  localparam int AW = PW + $clog2(MAX_TAPS) + 1;
  localparam int QW = AW + 1 - COEF_FRAC;

  logic signed [PW-1:0] prod_q;
  logic                 use_q;
  logic signed [AW-1:0] acc_d, acc_q;
  logic signed [AW:0]   rnd;
  logic signed [QW-1:0] quo;
  logic                 all_zero, all_one;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= 1'b0;
    end else begin
      use_q <= ctrl_i.use_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(smp_i) * PW'(coef_i);
  end

  // accumulate stage
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (use_q) begin
      acc_d = acc_q + AW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // round half up, floor shift, saturate
  assign rnd = $signed({acc_q[AW-1], acc_q})
             + $signed({{(AW - COEF_FRAC + 1){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}});
  assign quo = rnd[AW:COEF_FRAC];

  assign all_zero = ~|quo[QW-1:SW-1];
  assign all_one  = &quo[QW-1:SW-1];

  always_comb begin
    if (all_zero || all_one) begin
      filtered_o = quo[SW-1:0];
    end else if (quo[QW-1]) begin
      filtered_o = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      filtered_o = {1'b0, {(SW - 1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

/* sv/fir_filter_delay_compensated_core.sv */
// fir_filter_delay_compensated_core: a coefficient write or a sample that gives no result is
// taken in idle, an illegal-size sample passes the finish state; a sample with a result turns
// the rotating tap chain once, one product per cycle, time-reversed with offset passes before
// and after, then the result is registered on the return to idle, after any output wait.
// reset: coefficients, window and frame counter zero, tap_count 1, frame_length 65535,
// forward mode; no clearing pass. depends on fir_dc_pkg, fir_dc_cell, fir_dc_mac
`default_nettype none

module fir_filter_delay_compensated_core
  import fir_dc_pkg::*;
#(
  parameter int MAX_TAPS     = MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data_i,
  // input items
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic [COEF_IDX_W-1:0]        coef_index_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_value_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  // result items
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    filtered_o,
  output logic [FRAME_W-1:0]                position_o,
  output logic                              status_o
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PRE    = 6'b000010,
    ST_MAC    = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_POST   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e                state_d, state_q;
  logic [CNT_W-1:0]      cnt_d, cnt_q;
  logic [TAPS_W-1:0]     taps_q;
  logic [FRAME_W-1:0]    frame_len_q;
  logic                  rev_q;
  logic [FRAME_W-1:0]    fc_d, fc_q;
  logic [FRAME_W-1:0]    pos_d, pos_q;
  logic                  res_status_d, res_status_q;

  logic                  out_valid_q, out_status_q;
  logic signed [SAMPLE_WIDTH-1:0] out_filtered_q;
  logic [FRAME_W-1:0]    out_position_q;
  logic                  out_load;

  logic                  in_xfer, cfg_xfer;
  logic                  legal, emit;
  logic [FRAME_W-1:0]    fidx;
  logic [FRAME_W:0]      fnext;
  logic [TAPS_W-1:0]     half;
  logic [CNT_W-1:0]      tap_cnt;

  ring_ctrl_t            ring;
  mac_ctrl_t             mac;
  logic signed [SAMPLE_WIDTH-1:0] smp  [MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   coef [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] mac_filtered;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q      <= TAPS_W'(1);
      frame_len_q <= '1;
      rev_q       <= 1'b0;
    end else if (cfg_xfer) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TAP_COUNT: taps_q      <= cfg_data_i[TAPS_W-1:0];
        CFG_FRAME_LEN: frame_len_q <= cfg_data_i[FRAME_W-1:0];
        CFG_TIME_REV:  rev_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // size check, frame index and compensated position
  assign legal = (taps_q != '0) && (32'(taps_q) <= 32'(MAX_TAPS))
              && (frame_len_q != '0) && (frame_len_q >= FRAME_W'(taps_q));
  assign fidx  = (fc_q >= frame_len_q) ? '0 : fc_q;
  assign fnext = (FRAME_W + 1)'(fidx) + (FRAME_W + 1)'(1);
  assign fc_d  = (fnext >= (FRAME_W + 1)'(frame_len_q)) ? '0 : fnext[FRAME_W-1:0];
  assign emit  = (fnext >= (FRAME_W + 1)'(taps_q));
  assign half  = TAPS_W'(taps_q / HALF_DIVISOR);
  assign pos_d = rev_q ? (fidx - FRAME_W'(taps_q) + FRAME_W'(1) + FRAME_W'(half))
                       : (fidx - FRAME_W'(half));
  assign tap_cnt = CNT_W'(taps_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    ring         = '0;
    mac          = '0;
    out_load     = 1'b0;
    ring.wr_idx  = coef_index_i;
    ring.wr_val  = coef_value_i;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (op_e'(operation_i) == OP_COEF_WR) begin
            ring.wr_en = 1'b1;
          end else if (!legal) begin
            res_status_d = 1'b1;
            state_d      = ST_FINISH;
          end else begin
            ring.shift_in = 1'b1;
            if (emit) begin
              res_status_d = 1'b0;
              mac.clr      = 1'b1;
              cnt_d        = '0;
              state_d      = (rev_q && (taps_q > TAPS_W'(1))) ? ST_PRE : ST_MAC;
            end
          end
        end
      end
      ST_PRE: begin
        // offset the coefficient ring so the head holds the last tap
        ring.coef_fwd = 1'b1;
        if (cnt_q == tap_cnt - CNT_W'(2)) begin
          cnt_d   = '0;
          state_d = ST_MAC;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_MAC: begin
        // one full turn of both rings, one product per cycle
        ring.smp_rot  = 1'b1;
        ring.coef_fwd = !rev_q;
        ring.coef_bwd = rev_q;
        mac.use_en    = (cnt_q < tap_cnt);
        if (cnt_q == CNT_W'(MAX_TAPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = (rev_q && (taps_q > TAPS_W'(1))) ? ST_POST : ST_FINISH;
      end
      ST_POST: begin
        // bring the coefficient ring back home
        ring.coef_bwd = 1'b1;
        if (cnt_q == tap_cnt - CNT_W'(2)) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      fc_q         <= '0;
      res_status_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      res_status_q <= res_status_d;
      if (ring.shift_in) begin
        fc_q <= fc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring.shift_in) begin
      pos_q <= pos_d;
    end
  end

  // tap chain
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    fir_dc_cell #(
      .IDX (j),
      .SW  (SAMPLE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ring),
      .smp_prev_i  ((j == 0) ? sample_i : smp[(j + MAX_TAPS - 1) % MAX_TAPS]),
      .smp_next_i  (smp[(j + 1) % MAX_TAPS]),
      .coef_prev_i (coef[(j + MAX_TAPS - 1) % MAX_TAPS]),
      .coef_next_i (coef[(j + 1) % MAX_TAPS]),
      .smp_o       (smp[j]),
      .coef_o      (coef[j])
    );
  end

  // shared multiply-accumulate at the chain head
  fir_dc_mac #(
    .SW       (SAMPLE_WIDTH),
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac),
    .smp_i      (smp[0]),
    .coef_i     (coef[0]),
    .filtered_o (mac_filtered)
  );

  // output register, holds a result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_filtered_q <= res_status_q ? '0 : mac_filtered;
      out_position_q <= res_status_q ? '0 : pos_q;
      out_status_q   <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_filtered_q;
  assign position_o  = out_position_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire
